@@ design/v3alu_pkg.sv @@
// package for the three-component vector unit
// types, opcodes, register indexes and the saturation helper; no dependencies

package v3alu_pkg;

  localparam int CW     = 16;
  localparam int FB     = 8;
  localparam int COEF_W = 16;
  localparam int CFG_W  = 4 * COEF_W;
  localparam int IDX_W  = 2;
  localparam int PW     = 2 * CW;
  localparam int SUM_W  = PW + 4;

  typedef logic signed [CW-1:0]     comp_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PW-1:0]     prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [CFG_W-1:0]         col_t;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_SCALE = 4'd2,
    OP_DOT   = 4'd3,
    OP_CROSS = 4'd4,
    OP_MIN   = 4'd5,
    OP_MAX   = 4'd6,
    OP_EQUAL = 4'd7,
    OP_XFORM = 4'd8
  } op_t;

  typedef enum logic [IDX_W-1:0] {
    REG_COL_X = 2'd0,
    REG_COL_Y = 2'd1,
    REG_COL_Z = 2'd2
  } reg_idx_t;

  localparam col_t COL_X_RST = col_t'(64'd256);
  localparam col_t COL_Y_RST = col_t'(64'd16777216);
  localparam col_t COL_Z_RST = col_t'(64'd1099511627776);

  localparam sum_t SAT_HI = sum_t'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam sum_t SAT_LO = sum_t'(-(64'sd1 <<< (CW - 1)));

  typedef struct packed {
    comp_t val;
    logic  ovf;
  } sat_t;

  function automatic sat_t saturate(sum_t v);
    sat_t r;
    if (v > SAT_HI) begin
      r.val = SAT_HI[CW-1:0];
      r.ovf = 1'b1;
    end else if (v < SAT_LO) begin
      r.val = SAT_LO[CW-1:0];
      r.ovf = 1'b1;
    end else begin
      r.val = v[CW-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

endpackage

@@ design/v3alu_if.sv @@
// valid/ready channels for operand words and result words
// depends on v3alu_pkg

interface v3alu_in_if import v3alu_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [3:0] operation;
  comp_t      a_x;
  comp_t      a_y;
  comp_t      a_z;
  comp_t      b_x;
  comp_t      b_y;
  comp_t      b_z;
  comp_t      scale_factor;

  modport source (output valid, operation, a_x, a_y, a_z, b_x, b_y, b_z, scale_factor,
                  input ready);
  modport sink (input valid, operation, a_x, a_y, a_z, b_x, b_y, b_z, scale_factor,
                output ready);
endinterface

interface v3alu_out_if import v3alu_pkg::*; ();
  logic  valid;
  logic  ready;
  comp_t r_x;
  comp_t r_y;
  comp_t r_z;
  logic  is_equal;
  logic  overflow;

  modport source (output valid, r_x, r_y, r_z, is_equal, overflow, input ready);
  modport sink (input valid, r_x, r_y, r_z, is_equal, overflow, output ready);
endinterface

@@ design/vector3_alu_with_transform.sv @@
// three-component Q8.8 vector unit with a 3x4 affine transform matrix
// depends on v3alu_pkg and the channel interfaces in v3alu_if
// three stages: operand reg, nine 16x16 multipliers into a product reg,
// sum/floor/saturate into the result reg; throughput one word per cycle
// while the result channel is ready, as a stall there backs up the stages
// reset: synchronous rst empties the pipeline and loads the identity matrix

module vector3_alu_with_transform import v3alu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  v3alu_in_if.sink         src,
  v3alu_out_if.source      res
);

  col_t col [3];

  logic  s1_valid;
  op_t   s1_op;
  comp_t s1_a [3];
  comp_t s1_b [3];
  comp_t s1_k;

  logic  s2_valid;
  op_t   s2_op;
  comp_t s2_a [3];
  comp_t s2_b [3];
  logic  s2_eq;
  prod_t s2_prod [3][3];
  coef_t s2_trans [3];

  comp_t ma [3][3];
  comp_t mb [3][3];
  prod_t prod_next [3][3];

  logic out_free, s2_free, s1_free;

  sat_t  comp_res [3];
  sum_t  comp_sum [3];
  sum_t  dot_sum;
  comp_t r_next [3];
  logic  ovf_next;

  assign out_free  = !res.valid || res.ready;
  assign s2_free   = !s2_valid || out_free;
  assign s1_free   = !s1_valid || s2_free;
  assign src.ready = s1_free;

  // matrix columns
  always_ff @(posedge clk) begin
    if (rst) begin
      col[0] <= COL_X_RST;
      col[1] <= COL_Y_RST;
      col[2] <= COL_Z_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_COL_X: col[0] <= cfg_data;
        REG_COL_Y: col[1] <= cfg_data;
        REG_COL_Z: col[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // operand register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= src.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && src.valid) begin
      s1_op   <= op_t'(src.operation);
      s1_a[0] <= src.a_x;
      s1_a[1] <= src.a_y;
      s1_a[2] <= src.a_z;
      s1_b[0] <= src.b_x;
      s1_b[1] <= src.b_y;
      s1_b[2] <= src.b_z;
      s1_k    <= src.scale_factor;
    end
  end

  // multiplier operand select
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int j = 0; j < 3; j++) begin
        ma[c][j] = '0;
        mb[c][j] = '0;
      end
    end
    case (s1_op)
      OP_SCALE: begin
        for (int c = 0; c < 3; c++) begin
          ma[c][0] = s1_a[c];
          mb[c][0] = s1_k;
        end
      end
      OP_DOT: begin
        for (int c = 0; c < 3; c++) begin
          ma[c][0] = s1_a[c];
          mb[c][0] = s1_b[c];
        end
      end
      OP_CROSS: begin
        ma[0][0] = s1_a[1]; mb[0][0] = s1_b[2];
        ma[0][1] = s1_a[2]; mb[0][1] = s1_b[1];
        ma[1][0] = s1_a[2]; mb[1][0] = s1_b[0];
        ma[1][1] = s1_a[0]; mb[1][1] = s1_b[2];
        ma[2][0] = s1_a[0]; mb[2][0] = s1_b[1];
        ma[2][1] = s1_a[1]; mb[2][1] = s1_b[0];
      end
      OP_XFORM: begin
        for (int c = 0; c < 3; c++) begin
          for (int j = 0; j < 3; j++) begin
            ma[c][j] = s1_a[j];
            mb[c][j] = CW'(coef_t'(col[c][j*COEF_W +: COEF_W]));
          end
        end
      end
      default: ;
    endcase
    for (int c = 0; c < 3; c++) begin
      for (int j = 0; j < 3; j++) begin
        prod_next[c][j] = PW'(ma[c][j]) * PW'(mb[c][j]);
      end
    end
  end

  // product register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_valid) begin
      s2_op <= s1_op;
      s2_eq <= (s1_a[0] == s1_b[0]) && (s1_a[1] == s1_b[1]) && (s1_a[2] == s1_b[2]);
      for (int c = 0; c < 3; c++) begin
        s2_a[c]     <= s1_a[c];
        s2_b[c]     <= s1_b[c];
        s2_trans[c] <= (s1_op == OP_XFORM) ? coef_t'(col[c][3*COEF_W +: COEF_W]) : '0;
        for (int j = 0; j < 3; j++) begin
          s2_prod[c][j] <= prod_next[c][j];
        end
      end
    end
  end

  // sum, floor, saturate and select
  always_comb begin
    dot_sum = (SUM_W'(s2_prod[0][0]) + SUM_W'(s2_prod[1][0]) + SUM_W'(s2_prod[2][0])) >>> FB;
    for (int c = 0; c < 3; c++) begin
      comp_sum[c] = SUM_W'(s2_prod[c][0]) + SUM_W'(s2_prod[c][2])
                  + (SUM_W'(s2_trans[c]) <<< FB);
      if (s2_op == OP_CROSS) begin
        comp_sum[c] = comp_sum[c] - SUM_W'(s2_prod[c][1]);
      end else begin
        comp_sum[c] = comp_sum[c] + SUM_W'(s2_prod[c][1]);
      end
      comp_sum[c] = comp_sum[c] >>> FB;
      comp_res[c] = '0;
      r_next[c]   = '0;
    end
    ovf_next = 1'b0;
    case (s2_op)
      OP_ADD, OP_SUB: begin
        for (int c = 0; c < 3; c++) begin
          if (s2_op == OP_ADD) begin
            comp_res[c] = saturate(SUM_W'(s2_a[c]) + SUM_W'(s2_b[c]));
          end else begin
            comp_res[c] = saturate(SUM_W'(s2_a[c]) - SUM_W'(s2_b[c]));
          end
          r_next[c] = comp_res[c].val;
        end
        ovf_next = comp_res[0].ovf || comp_res[1].ovf || comp_res[2].ovf;
      end
      OP_SCALE, OP_CROSS, OP_XFORM: begin
        for (int c = 0; c < 3; c++) begin
          comp_res[c] = saturate(comp_sum[c]);
          r_next[c]   = comp_res[c].val;
        end
        ovf_next = comp_res[0].ovf || comp_res[1].ovf || comp_res[2].ovf;
      end
      OP_DOT: begin
        comp_res[0] = saturate(dot_sum);
        r_next[0]   = comp_res[0].val;
        ovf_next    = comp_res[0].ovf;
      end
      OP_MIN: begin
        for (int c = 0; c < 3; c++) begin
          r_next[c] = (s2_a[c] < s2_b[c]) ? s2_a[c] : s2_b[c];
        end
      end
      OP_MAX: begin
        for (int c = 0; c < 3; c++) begin
          r_next[c] = (s2_a[c] > s2_b[c]) ? s2_a[c] : s2_b[c];
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_free) begin
      res.valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_valid) begin
      res.r_x      <= r_next[0];
      res.r_y      <= r_next[1];
      res.r_z      <= r_next[2];
      res.is_equal <= s2_eq;
      res.overflow <= ovf_next;
    end
  end

endmodule

@@ tb/sv/tb_vector3_alu_with_transform.sv @@
`timescale 1ns / 1ps
// self-checking bench for the Q8.8 vector unit: directed corners, matrix extremes,
// back-to-back words and a long random mix, each result checked against an own model
// depends on v3alu_pkg, the channel interfaces in v3alu_if and the unit itself

module tb_vector3_alu_with_transform import v3alu_pkg::*; ();

  typedef struct packed {
    logic [3:0] operation;
    comp_t      a_x;
    comp_t      a_y;
    comp_t      a_z;
    comp_t      b_x;
    comp_t      b_y;
    comp_t      b_z;
    comp_t      scale_factor;
  } vec_word_t;

  typedef struct packed {
    comp_t r_x;
    comp_t r_y;
    comp_t r_z;
    logic  is_equal;
    logic  overflow;
  } vec_result_t;

  localparam logic [3:0] OP_SPARE_LO = 4'd9;
  localparam logic [3:0] OP_SPARE_HI = 4'd15;
  localparam comp_t      Q_MAX       = 16'sh7FFF;
  localparam comp_t      Q_MIN       = 16'sh8000;
  localparam comp_t      Q_ONE       = 16'sh0100;
  localparam longint     LIM_HI      = (64'sd1 <<< (CW - 1)) - 64'sd1;
  localparam longint     LIM_LO      = -LIM_HI - 64'sd1;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  v3alu_in_if  src_if ();
  v3alu_out_if res_if ();

  vector3_alu_with_transform dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .src       (src_if),
    .res       (res_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  col_t        mat_col [3];
  vec_result_t pending_vec_results [$];
  bit          calm = 1'b0;
  bit          word_up = 1'b0;
  int          burst_left = 0;
  int          mismatches = 0;
  int          leftover = 0;
  int          n_words = 0;
  int          n_xform = 0;
  int          n_equal = 0;
  int          n_sat = 0;
  int          n_settings = 0;

  function automatic comp_t clamp_q88(input longint v, inout logic ovf);
    if (v > LIM_HI) begin
      ovf = 1'b1;
      return Q_MAX;
    end
    if (v < LIM_LO) begin
      ovf = 1'b1;
      return Q_MIN;
    end
    return comp_t'(v);
  endfunction

  function automatic longint coef_row(input col_t c, input int row);
    coef_t cv;
    cv = c[row*COEF_W +: COEF_W];
    return cv;
  endfunction

  function automatic vec_result_t vector_op_result(input vec_word_t w);
    longint      av [3];
    longint      bv [3];
    longint      acc;
    comp_t       rc [3];
    logic        ovf;
    int          i;
    int          j;
    int          p;
    int          q;
    vec_result_t r;
    av[0] = w.a_x;
    av[1] = w.a_y;
    av[2] = w.a_z;
    bv[0] = w.b_x;
    bv[1] = w.b_y;
    bv[2] = w.b_z;
    for (i = 0; i < 3; i++) rc[i] = '0;
    ovf = 1'b0;
    case (w.operation)
      OP_ADD: for (i = 0; i < 3; i++) rc[i] = clamp_q88(av[i] + bv[i], ovf);
      OP_SUB: for (i = 0; i < 3; i++) rc[i] = clamp_q88(av[i] - bv[i], ovf);
      OP_SCALE: begin
        for (i = 0; i < 3; i++)
          rc[i] = clamp_q88((longint'(w.scale_factor) * av[i]) >>> FB, ovf);
      end
      OP_DOT: begin
        acc = av[0] * bv[0] + av[1] * bv[1] + av[2] * bv[2];
        rc[0] = clamp_q88(acc >>> FB, ovf);
      end
      OP_CROSS: begin
        for (i = 0; i < 3; i++) begin
          p = (i + 1) % 3;
          q = (i + 2) % 3;
          rc[i] = clamp_q88((av[p] * bv[q] - av[q] * bv[p]) >>> FB, ovf);
        end
      end
      OP_MIN: for (i = 0; i < 3; i++) rc[i] = (av[i] < bv[i]) ? comp_t'(av[i]) : comp_t'(bv[i]);
      OP_MAX: for (i = 0; i < 3; i++) rc[i] = (av[i] > bv[i]) ? comp_t'(av[i]) : comp_t'(bv[i]);
      OP_XFORM: begin
        for (i = 0; i < 3; i++) begin
          // translation row aligned to the product scale
          acc = coef_row(mat_col[i], 3) <<< FB;
          for (j = 0; j < 3; j++) acc += av[j] * coef_row(mat_col[i], j);
          rc[i] = clamp_q88(acc >>> FB, ovf);
        end
      end
      default: ;
    endcase
    r.r_x      = rc[0];
    r.r_y      = rc[1];
    r.r_z      = rc[2];
    r.is_equal = (w.a_x == w.b_x) && (w.a_y == w.b_y) && (w.a_z == w.b_z);
    r.overflow = ovf;
    return r;
  endfunction

  function automatic vec_word_t vec_word(input logic [3:0] op, input comp_t ax, input comp_t ay,
                                         input comp_t az, input comp_t bx, input comp_t by,
                                         input comp_t bz, input comp_t k);
    vec_word_t w;
    w.operation    = op;
    w.a_x          = ax;
    w.a_y          = ay;
    w.a_z          = az;
    w.b_x          = bx;
    w.b_y          = by;
    w.b_z          = bz;
    w.scale_factor = k;
    return w;
  endfunction

  function automatic comp_t q88_value();
    case ($urandom_range(0, 7))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return comp_t'(int'($urandom_range(0, 1023)) - 512);
      3: return comp_t'(int'($urandom_range(0, 7)) - 4);
      default: return comp_t'($urandom);
    endcase
  endfunction

  function automatic logic [3:0] random_op();
    if ($urandom_range(0, 24) == 0) return 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    if ($urandom_range(0, 3) == 0) return OP_XFORM;
    return 4'($urandom_range(OP_ADD, OP_XFORM));
  endfunction

  function automatic vec_word_t random_vec_word(input logic [3:0] op);
    vec_word_t w;
    w = vec_word(op, q88_value(), q88_value(), q88_value(), q88_value(), q88_value(),
                 q88_value(), q88_value());
    case ($urandom_range(0, 9))
      0: begin
        w.b_x = w.a_x;
        w.b_y = w.a_y;
        w.b_z = w.a_z;
      end
      1: begin
        w.b_x = w.a_x;
        w.b_y = w.a_y;
        w.b_z = w.a_z ^ comp_t'(16'h1 << $urandom_range(0, CW - 1));
      end
      default: ;
    endcase
    return w;
  endfunction

  function automatic col_t random_column();
    col_t c;
    int   r;
    case ($urandom_range(0, 6))
      0: c = {4{Q_MAX}};
      1: c = {4{Q_MIN}};
      2: c = '0;
      3: c = '1;
      4: for (r = 0; r < 4; r++) c[r*COEF_W +: COEF_W] = coef_t'(int'($urandom_range(0, 1023)) - 512);
      default: c = {$urandom, $urandom};
    endcase
    return c;
  endfunction

  // one word through the input channel, sender bursts and gaps included
  task automatic send_vec_word(input vec_word_t w);
    int          gap;
    vec_result_t r;
    if (!calm && burst_left <= 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    src_if.valid        <= 1'b1;
    src_if.operation    <= w.operation;
    src_if.a_x          <= w.a_x;
    src_if.a_y          <= w.a_y;
    src_if.a_z          <= w.a_z;
    src_if.b_x          <= w.b_x;
    src_if.b_y          <= w.b_y;
    src_if.b_z          <= w.b_z;
    src_if.scale_factor <= w.scale_factor;
    word_up = 1'b1;
    do @(posedge clk); while (!src_if.ready);
    r = vector_op_result(w);
    pending_vec_results.push_back(r);
    n_words++;
    if (w.operation == OP_XFORM) n_xform++;
    if (r.is_equal) n_equal++;
    if (r.overflow) n_sat++;
    burst_left--;
    if (!calm && burst_left <= 0) begin
      src_if.valid <= 1'b0;
      word_up = 1'b0;
    end
  endtask

  task automatic close_stream();
    if (word_up) begin
      src_if.valid <= 1'b0;
      word_up = 1'b0;
    end
    burst_left = 0;
  endtask

  task automatic wait_results_drained();
    int spins;
    spins = 0;
    while (pending_vec_results.size() != 0 && spins < 5000) begin
      @(posedge clk);
      spins++;
    end
  endtask

  // only while idle: all three columns, one per cycle
  task automatic load_matrix(input col_t cx, input col_t cy, input col_t cz);
    col_t cols [3];
    int   i;
    cols[0] = cx;
    cols[1] = cy;
    cols[2] = cz;
    for (i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_data  <= cols[i];
      @(posedge clk);
      mat_col[i] = cols[i];
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic end_phase();
    close_stream();
    wait_results_drained();
  endtask

  task automatic test_directed_corners();
    send_vec_word(vec_word(OP_ADD, Q_MAX, Q_MIN, Q_ONE, 16'sh0001, -16'sh0001, -Q_ONE, '0));
    send_vec_word(vec_word(OP_SUB, Q_MIN, Q_MAX, 16'sh1234, 16'sh0001, Q_MIN, 16'sh1234, '0));
    send_vec_word(vec_word(OP_ADD, Q_ONE, 16'sh0200, -16'sh0300, Q_ONE, 16'sh0200, -16'sh0300,
                           Q_MAX));
    send_vec_word(vec_word(OP_SCALE, Q_MIN, Q_MAX, Q_ONE, '0, '0, '0, Q_MAX));
    send_vec_word(vec_word(OP_SCALE, Q_MIN, 16'sh0001, -16'sh0001, '0, '0, '0, Q_MIN));
    send_vec_word(vec_word(OP_SCALE, 16'sh0001, 16'sh00FF, Q_ONE, '0, '0, '0, -16'sh0001));
    send_vec_word(vec_word(OP_SCALE, Q_MAX, Q_MIN, Q_MAX, '0, '0, '0, '0));
    send_vec_word(vec_word(OP_DOT, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, '0));
    send_vec_word(vec_word(OP_DOT, Q_ONE, 16'sh0200, 16'sh0300, Q_ONE, -Q_ONE, 16'sh0080, '0));
    send_vec_word(vec_word(OP_DOT, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, '0));
    send_vec_word(vec_word(OP_CROSS, Q_ONE, '0, '0, '0, Q_ONE, '0, '0));
    send_vec_word(vec_word(OP_CROSS, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, '0));
    send_vec_word(vec_word(OP_CROSS, '0, 16'sh0001, '0, '0, '0, -16'sh0001, '0));
    send_vec_word(vec_word(OP_MIN, Q_MAX, Q_MIN, 16'sh0005, Q_MIN, Q_MAX, 16'sh0005, '0));
    send_vec_word(vec_word(OP_MAX, Q_MAX, Q_MIN, 16'sh0005, Q_MIN, Q_MAX, 16'sh0005, '0));
    send_vec_word(vec_word(OP_EQUAL, Q_MAX, Q_MIN, 16'sh0003, Q_MAX, Q_MIN, 16'sh0003, Q_MAX));
    send_vec_word(vec_word(OP_EQUAL, 16'sh0001, 16'sh0002, 16'sh0003, 16'sh0001, 16'sh0002,
                           16'sh0004, '0));
    send_vec_word(vec_word(OP_XFORM, 16'sh0123, -16'sh0456, Q_MAX, '0, '0, '0, '0));
    send_vec_word(vec_word(OP_XFORM, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    send_vec_word(vec_word(OP_SPARE_LO, Q_MAX, Q_ONE, Q_MIN, Q_MAX, Q_ONE, Q_MIN, Q_MAX));
    send_vec_word(vec_word(OP_SPARE_HI, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    end_phase();
  endtask

  task automatic test_matrix_extremes();
    col_t sets [5];
    int   s;
    int   n;
    sets[0] = '0;
    sets[1] = '1;
    sets[2] = {4{Q_MAX}};
    sets[3] = {4{Q_MIN}};
    sets[4] = {Q_MIN, Q_MAX, -Q_ONE, Q_ONE};
    for (s = 0; s < 5; s++) begin
      load_matrix(sets[s], sets[(s + 1) % 5], sets[(s + 3) % 5]);
      for (n = 0; n < 24; n++)
        send_vec_word(random_vec_word(($urandom_range(0, 2) != 0) ? OP_XFORM : random_op()));
      end_phase();
    end
  endtask

  task automatic test_back_to_back();
    int n;
    calm = 1'b1;
    for (n = 0; n < 150; n++) send_vec_word(random_vec_word(random_op()));
    end_phase();
    calm = 1'b0;
  endtask

  task automatic test_random_mix();
    int ph;
    int n;
    for (ph = 0; ph < 9; ph++) begin
      load_matrix(random_column(), random_column(), random_column());
      for (n = 0; n < 110; n++) send_vec_word(random_vec_word(random_op()));
      end_phase();
    end
  endtask

  // receiver stalls on a rotating mask, reloaded now and then
  initial begin
    logic [15:0] stall_mask;
    int          stall_ph;
    stall_mask = 16'hFFFF;
    stall_ph = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_ph % 48 == 0)
        stall_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      stall_ph++;
      res_if.ready <= calm || stall_mask[stall_ph % 16];
    end
  end

  always @(posedge clk) begin
    vec_result_t want;
    vec_result_t got;
    if (!rst && res_if.valid && res_if.ready) begin
      got = {res_if.r_x, res_if.r_y, res_if.r_z, res_if.is_equal, res_if.overflow};
      if (pending_vec_results.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected result word x=%h y=%h z=%h eq=%b ovf=%b", $time,
                   got.r_x, got.r_y, got.r_z, got.is_equal, got.overflow);
        mismatches++;
      end else begin
        want = pending_vec_results.pop_front();
        if (got.r_x !== want.r_x || got.r_y !== want.r_y || got.r_z !== want.r_z ||
            got.is_equal !== want.is_equal || got.overflow !== want.overflow) begin
          if (mismatches < 10)
            $display("%0t: mismatch expected x=%h y=%h z=%h eq=%b ovf=%b, got x=%h y=%h z=%h eq=%b ovf=%b",
                     $time, want.r_x, want.r_y, want.r_z, want.is_equal, want.overflow,
                     got.r_x, got.r_y, got.r_z, got.is_equal, got.overflow);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= REG_COL_X;
    cfg_data            <= '0;
    src_if.valid        <= 1'b0;
    src_if.operation    <= OP_ADD;
    src_if.a_x          <= '0;
    src_if.a_y          <= '0;
    src_if.a_z          <= '0;
    src_if.b_x          <= '0;
    src_if.b_y          <= '0;
    src_if.b_z          <= '0;
    src_if.scale_factor <= '0;
    mat_col[REG_COL_X] = COL_X_RST;
    mat_col[REG_COL_Y] = COL_Y_RST;
    mat_col[REG_COL_Z] = COL_Z_RST;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed_corners();
    test_matrix_extremes();
    test_back_to_back();
    test_random_mix();

    wait_results_drained();
    repeat (8) @(posedge clk);
    leftover = pending_vec_results.size();
    if (leftover != 0) $display("%0d result words never arrived", leftover);
    $display("covered %0d words: %0d transforms, %0d equal flags, %0d saturated results",
             n_words, n_xform, n_equal, n_sat);
    $display("matrix loaded with %0d settings, %0d mismatches", n_settings, mismatches);
    if (mismatches == 0 && leftover == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
